@@ rtl/core/vfpe_pkg.sv @@
// ============================================================================
// vfpe_pkg
// Shared types, constants and the control store of the volume fade engine.
// ============================================================================
package vfpe_pkg;

    localparam int LEVEL_W    = 8;
    localparam int MS_W       = 16;
    localparam int GAIN_W     = 9;
    localparam int RATIO_W    = 17;                 // Q16, 65536 = 1.0
    localparam int BG_W       = LEVEL_W + GAIN_W;   // base volume times gain
    localparam int PROD_W     = BG_W + RATIO_W;
    localparam int PROD_SHIFT = 24;
    localparam int DIV_STEPS  = MS_W;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);

    localparam int S_DATA_W   = 40;                 // 33 bits of fields, byte aligned
    localparam int M_DATA_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [RATIO_W-1:0] RATIO_ONE  = RATIO_W'(65536);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'd255;
    localparam logic [LEVEL_W-1:0] PAN_CENTRE = 8'd128;
    localparam logic [LEVEL_W-1:0] PAN_RIGHT_KNEE = 8'd127;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_VOLUME  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_POSITION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MUTE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_MUTE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE  = 3'd5;

    localparam logic MODE_START = 1'b1;

    typedef logic [2:0] step_t;

    localparam step_t STEP_WAIT      = 3'd0;
    localparam step_t STEP_DECODE    = 3'd1;
    localparam step_t STEP_CHECK_END = 3'd2;
    localparam step_t STEP_DIV       = 3'd3;
    localparam step_t STEP_RATIO     = 3'd4;
    localparam step_t STEP_MUL_GAIN  = 3'd5;
    localparam step_t STEP_MUL_RATIO = 3'd6;
    localparam step_t STEP_EMIT      = 3'd7;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_DECODE,
        OP_CHECK_END,
        OP_DIV_STEP,
        OP_RATIO,
        OP_MUL_GAIN,
        OP_MUL_RATIO,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_NO_ACCEPT,
        COND_NO_RESULT,
        COND_AT_END,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic no_result;
        logic at_end;
        logic div_busy;
    } status_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] base_volume;
        logic [LEVEL_W-1:0] pan_position;
        logic               channel_mute;
        logic               global_mute;
        logic [GAIN_W-1:0]  master_gain;
        logic               stereo_mode;
    } cfg_t;

    // Control store: a taken condition jumps to target, else the step advances.
    // The emit step falls through to the wait step by wrapping the step counter.
    function automatic ctrl_word_t ucode_word(input step_t step);
        ctrl_word_t w;
        begin
            w = '{op: OP_WAIT, cond: COND_NO_ACCEPT, target: STEP_WAIT};
            case (step)
                STEP_WAIT:      w = '{op: OP_WAIT,      cond: COND_NO_ACCEPT, target: STEP_WAIT};
                STEP_DECODE:    w = '{op: OP_DECODE,    cond: COND_NO_RESULT, target: STEP_WAIT};
                STEP_CHECK_END: w = '{op: OP_CHECK_END, cond: COND_AT_END,
                                      target: STEP_MUL_GAIN};
                STEP_DIV:       w = '{op: OP_DIV_STEP,  cond: COND_DIV_BUSY,  target: STEP_DIV};
                STEP_RATIO:     w = '{op: OP_RATIO,     cond: COND_NEXT,      target: STEP_WAIT};
                STEP_MUL_GAIN:  w = '{op: OP_MUL_GAIN,  cond: COND_NEXT,      target: STEP_WAIT};
                STEP_MUL_RATIO: w = '{op: OP_MUL_RATIO, cond: COND_NEXT,      target: STEP_WAIT};
                STEP_EMIT:      w = '{op: OP_EMIT,      cond: COND_OUT_BUSY,  target: STEP_EMIT};
                default:        w = '{op: OP_WAIT,      cond: COND_NO_ACCEPT, target: STEP_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

@@ rtl/core/volume_fade_pan_engine.sv @@
// ============================================================================
// volume_fade_pan_engine
// Linear volume fade with mute, master gain and stereo pan, run by a
// microcoded sequencer over a small arithmetic datapath.
// ============================================================================
// A mid-fade tick runs the one-bit-per-cycle ratio divider; the final tick
//   skips it. A start item or a tick with no fade gives no result.
// A new item is taken only in the wait step, once the last one is through;
//   the emit step holds while the output register is still full.
// Reset clears the fade state and loads register defaults; no clearing pass.
module volume_fade_pan_engine
    import vfpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // elapsed_ms[15:0], fade_down[16], fade_ms[32:17]
    input  logic                  s_tuser,   // mode

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // left_volume[7:0], right_volume[15:8]
    output logic                  m_tlast,   // fade_finished

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg, cfg_next;
    step_t      step_reg, step_next;
    ctrl_word_t ctrl;
    status_t    status;
    logic       jump;
    logic       accept;
    logic       out_busy;

    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] out_left_reg, out_left_next;
    logic [LEVEL_W-1:0] out_right_reg, out_right_next;
    logic               out_last_reg, out_last_next;

    logic [LEVEL_W-1:0] dp_left;
    logic [LEVEL_W-1:0] dp_right;
    logic               dp_finished;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_VOLUME:  cfg_next.base_volume  = cfg_data[LEVEL_W-1:0];
                REG_PAN_POSITION: cfg_next.pan_position = cfg_data[LEVEL_W-1:0];
                REG_CHANNEL_MUTE: cfg_next.channel_mute = cfg_data[0];
                REG_GLOBAL_MUTE:  cfg_next.global_mute  = cfg_data[0];
                REG_MASTER_GAIN:  cfg_next.master_gain  = cfg_data[GAIN_W-1:0];
                REG_STEREO_MODE:  cfg_next.stereo_mode  = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // sequencer
    assign ctrl     = ucode_word(step_reg);
    assign s_tready = (ctrl.op == OP_WAIT);
    assign accept   = s_tvalid && s_tready;
    assign out_busy = out_valid_reg && !m_tready;

    always_comb
    begin
        case (ctrl.cond)
            COND_NEXT:      jump = 1'b0;
            COND_NO_ACCEPT: jump = !s_tvalid;
            COND_NO_RESULT: jump = status.no_result;
            COND_AT_END:    jump = status.at_end;
            COND_DIV_BUSY:  jump = status.div_busy;
            COND_OUT_BUSY:  jump = out_busy;
            default:        jump = 1'b0;
        endcase
    end

    // the last step wraps to the wait step
    assign step_next = jump ? ctrl.target : step_reg + step_t'(1);

    // output register: load on emit, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if ((ctrl.op == OP_EMIT) && !out_busy)
        begin
            out_valid_next = 1'b1;
            out_left_next  = dp_left;
            out_right_next = dp_right;
            out_last_next  = dp_finished;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_volume  <= LEVEL_MAX;
            cfg_reg.pan_position <= PAN_CENTRE;
            cfg_reg.channel_mute <= 1'b0;
            cfg_reg.global_mute  <= 1'b0;
            cfg_reg.master_gain  <= GAIN_W'(256);
            cfg_reg.stereo_mode  <= 1'b0;
            step_reg             <= STEP_WAIT;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_last_reg  <= out_last_next;
    end

    vfpe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (ctrl.op),
        .take          (accept),
        .in_mode       (s_tuser),
        .in_elapsed_ms (s_tdata[15:0]),
        .in_fade_down  (s_tdata[16]),
        .in_fade_ms    (s_tdata[32:17]),
        .cfg           (cfg_reg),
        .status        (status),
        .left_volume   (dp_left),
        .right_volume  (dp_right),
        .fade_finished (dp_finished)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_right_reg, out_left_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_accept_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (step_reg == STEP_DECODE))
        else $error("accepted item not followed by decode step");

    a_load_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(ctrl.op) == OP_EMIT))
        else $error("result loaded outside the emit step");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ((ctrl.op == OP_EMIT) && out_busy) |=> (step_reg == STEP_EMIT))
        else $error("emit step left while the output register was full");
`endif

endmodule

@@ rtl/core/vfpe_datapath.sv @@
// ============================================================================
// vfpe_datapath
// Fade state, serial ratio divider, gain multipliers and pan/mute output stage.
// ============================================================================
module vfpe_datapath
    import vfpe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  op_t                op,
    input  logic               take,
    input  logic               in_mode,
    input  logic [MS_W-1:0]    in_elapsed_ms,
    input  logic               in_fade_down,
    input  logic [MS_W-1:0]    in_fade_ms,
    input  cfg_t               cfg,
    output status_t            status,
    output logic [LEVEL_W-1:0] left_volume,
    output logic [LEVEL_W-1:0] right_volume,
    output logic               fade_finished
);

    logic               mode_reg, mode_next;
    logic [MS_W-1:0]    elapsed_reg, elapsed_next;
    logic               fade_down_reg, fade_down_next;
    logic [MS_W-1:0]    fade_ms_reg, fade_ms_next;

    logic [MS_W-1:0]    length_reg, length_next;
    logic [MS_W-1:0]    progress_reg, progress_next;
    logic               direction_reg, direction_next;

    logic [MS_W-1:0]    rem_reg, rem_next;
    logic [MS_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic               finished_reg, finished_next;
    logic [BG_W-1:0]    bg_reg, bg_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;

    logic [MS_W:0]      rem_shift;
    logic [MS_W:0]      progress_sum;
    logic [PROD_W-PROD_SHIFT-1:0] level_wide;
    logic [LEVEL_W-1:0] level;
    logic               silent;
    logic [LEVEL_W:0]   left_cut;
    logic [LEVEL_W:0]   right_cut;

    assign rem_shift    = {rem_reg, 1'b0};
    assign progress_sum = {1'b0, progress_reg} + {1'b0, elapsed_reg};

    always_comb
    begin
        mode_next      = mode_reg;
        elapsed_next   = elapsed_reg;
        fade_down_next = fade_down_reg;
        fade_ms_next   = fade_ms_reg;
        length_next    = length_reg;
        progress_next  = progress_reg;
        direction_next = direction_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        ratio_next     = ratio_reg;
        finished_next  = finished_reg;
        bg_next        = bg_reg;
        prod_next      = prod_reg;

        case (op)
            OP_WAIT:
            begin
                if (take)
                begin
                    mode_next      = in_mode;
                    elapsed_next   = in_elapsed_ms;
                    fade_down_next = in_fade_down;
                    fade_ms_next   = in_fade_ms;
                end
            end
            OP_DECODE:
            begin
                if (mode_reg == MODE_START)
                begin
                    direction_next = fade_down_reg;
                    progress_next  = '0;
                    length_next    = fade_ms_reg;
                end
            end
            OP_CHECK_END:
            begin
                if (progress_reg >= length_reg)
                begin
                    // final level: full for a fade-in, silence for a fade-out
                    ratio_next    = direction_reg ? '0 : RATIO_ONE;
                    finished_next = 1'b1;
                    length_next   = '0;
                end
                else
                begin
                    rem_next      = progress_reg;
                    quo_next      = '0;
                    cnt_next      = CNT_W'(DIV_STEPS);
                    finished_next = 1'b0;
                end
            end
            OP_DIV_STEP:
            begin
                // restoring divide, one quotient bit per step
                if (rem_shift >= {1'b0, length_reg})
                begin
                    rem_next = MS_W'(rem_shift - {1'b0, length_reg});
                    quo_next = {quo_reg[MS_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[MS_W-1:0];
                    quo_next = {quo_reg[MS_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
            OP_RATIO:
            begin
                ratio_next = direction_reg ? RATIO_ONE - {1'b0, quo_reg} : {1'b0, quo_reg};
                if (progress_sum < {1'b0, length_reg})
                begin
                    progress_next = progress_sum[MS_W-1:0];
                end
                else
                begin
                    progress_next = length_reg;
                end
            end
            OP_MUL_GAIN:
            begin
                bg_next = BG_W'(cfg.base_volume) * BG_W'(cfg.master_gain);
            end
            OP_MUL_RATIO:
            begin
                prod_next = PROD_W'(bg_reg) * PROD_W'(ratio_reg);
            end
            OP_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            progress_reg  <= '0;
            direction_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            length_reg    <= length_next;
            progress_reg  <= progress_next;
            direction_reg <= direction_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        elapsed_reg   <= elapsed_next;
        fade_down_reg <= fade_down_next;
        fade_ms_reg   <= fade_ms_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        ratio_reg     <= ratio_next;
        finished_reg  <= finished_next;
        bg_reg        <= bg_next;
        prod_reg      <= prod_next;
    end

    assign status.no_result = (mode_reg == MODE_START) || (length_reg == '0);
    assign status.at_end    = progress_reg >= length_reg;
    assign status.div_busy  = cnt_reg != CNT_W'(1);

    // level = product >> 24, clamped to 255
    assign level_wide = prod_reg[PROD_W-1:PROD_SHIFT];
    assign level      = (level_wide > {2'b00, LEVEL_MAX}) ? LEVEL_MAX : level_wide[LEVEL_W-1:0];
    assign silent     = cfg.channel_mute || cfg.global_mute || (cfg.base_volume == '0);

    // pan cut: right side drops below the knee, left side drops above centre
    always_comb
    begin
        left_cut  = '0;
        right_cut = '0;
        if (cfg.pan_position < PAN_RIGHT_KNEE)
        begin
            right_cut = {(PAN_RIGHT_KNEE - cfg.pan_position), 1'b0};
        end
        if (cfg.pan_position > PAN_CENTRE)
        begin
            left_cut = {(cfg.pan_position - PAN_CENTRE), 1'b0};
        end
    end

    always_comb
    begin
        left_volume  = '0;
        right_volume = '0;
        if (!silent)
        begin
            if (!cfg.stereo_mode)
            begin
                left_volume = level;
            end
            else
            begin
                if ({1'b0, level} > left_cut)
                begin
                    left_volume = LEVEL_W'({1'b0, level} - left_cut);
                end
                if ({1'b0, level} > right_cut)
                begin
                    right_volume = LEVEL_W'({1'b0, level} - right_cut);
                end
            end
        end
    end

    assign fade_finished = finished_reg;

`ifndef SYNTHESIS
    a_progress_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (length_reg != '0) |-> (progress_reg <= length_reg))
        else $error("fade progress ran past the fade length");

    a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_DIV_STEP) |-> (cnt_reg != '0))
        else $error("divide step with an exhausted step count");
`endif

endmodule
